### rtl/wrps_pkg.sv
package wrps_pkg;

  localparam int MAX_RECTS_DEF = 64;
  localparam int COORD_W       = 16;
  localparam int SPAN_W        = COORD_W + 1;
  localparam int MUL_W         = 32;
  localparam int PROD_W        = 2 * MUL_W;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_PICK  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_INVERTED = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] xl;
    logic signed [COORD_W-1:0] yb;
    logic signed [COORD_W-1:0] xr;
    logic signed [COORD_W-1:0] yt;
  } rect_t;

endpackage

### rtl/wrps_mul.sv
module wrps_mul (
  input  logic                             clk,
  input  logic [wrps_pkg::MUL_W-1:0]       a,
  input  logic [wrps_pkg::MUL_W-1:0]       b,
  output logic [wrps_pkg::PROD_W-1:0]      prod
);

  // shared unsigned multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= wrps_pkg::PROD_W'(a) * wrps_pkg::PROD_W'(b);
  end

endmodule

### rtl/wrps_table.sv
module wrps_table #(
  parameter int MAX_RECTS = wrps_pkg::MAX_RECTS_DEF,
  parameter int TOT_W     = $clog2(wrps_pkg::MAX_RECTS_DEF) + 33
) (
  input  logic                                             clk,
  input  logic                                             wr_en,
  input  logic [((MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1)-1:0] wr_addr,
  input  wrps_pkg::rect_t                                  wr_rect,
  input  logic [TOT_W-1:0]                                 wr_tot,
  input  logic [((MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1)-1:0] rd_addr,
  output wrps_pkg::rect_t                                  rd_rect,
  output logic [TOT_W-1:0]                                 rd_tot
);

  wrps_pkg::rect_t  rect_mem [MAX_RECTS];
  logic [TOT_W-1:0] tot_mem  [MAX_RECTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rect_mem[wr_addr] <= wr_rect;
      tot_mem[wr_addr]  <= wr_tot;
    end
    rd_rect <= rect_mem[rd_addr];
    rd_tot  <= tot_mem[rd_addr];
  end

endmodule

### rtl/weighted_rect_point_sampler_unit.sv
// channel  | handshake          | payload
// input    | in_valid/in_stall  | cmd, x_left, y_bottom, x_right, y_top, rand_select, rand_x, rand_y
// output   | out_valid/out_stall| status, point_x, point_y
// one item at a time; in_stall is high from acceptance until the result is loaded
// clear, unused command and rejected add: straight to ST_FIN, then the output register
// accepted add: table read, one multiply, table write, then the output register
// pick: a bisection of at most ceil(log2(count)) steps over the one table read port
// reset empties the table; stored rectangles and totals are not cleared
// a stalled result holds in the output register while the next item is already accepted
module weighted_rect_point_sampler_unit #(
  parameter int MAX_RECTS = wrps_pkg::MAX_RECTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              cmd,
  input  logic signed [wrps_pkg::COORD_W-1:0]     x_left,
  input  logic signed [wrps_pkg::COORD_W-1:0]     y_bottom,
  input  logic signed [wrps_pkg::COORD_W-1:0]     x_right,
  input  logic signed [wrps_pkg::COORD_W-1:0]     y_top,
  input  logic [31:0]                             rand_select,
  input  logic [31:0]                             rand_x,
  input  logic [31:0]                             rand_y,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [1:0]                              status,
  output logic signed [wrps_pkg::COORD_W-1:0]     point_x,
  output logic signed [wrps_pkg::COORD_W-1:0]     point_y
);

  localparam int IDX_W  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W  = $clog2(MAX_RECTS + 1);
  localparam int TOT_W  = $clog2(MAX_RECTS) + 33;
  localparam int MUL_W  = wrps_pkg::MUL_W;
  localparam int SPAN_W = wrps_pkg::SPAN_W;
  localparam int CW     = wrps_pkg::COORD_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD_MUL, ST_ADD_WR, ST_PK_LO, ST_PK_HI, ST_PK_S, ST_SRCH,
    ST_CMP, ST_RECT, ST_MX, ST_MY, ST_FY, ST_FIN
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       cnt;
  wrps_pkg::rect_t        rect_q;
  logic [31:0]            rsel_q;
  logic [31:0]            rx_q;
  logic [31:0]            ry_q;
  logic [SPAN_W-1:0]      w_q;
  logic [SPAN_W-1:0]      h_q;
  logic [TOT_W-1:0]       prev_q;
  logic [TOT_W-1:0]       total_q;
  logic [31:0]            part_q;
  logic [TOT_W-1:0]       s_q;
  logic [IDX_W-1:0]       lo;
  logic [IDX_W-1:0]       hi;
  logic [1:0]             res_status;
  logic signed [CW-1:0]   res_x;
  logic signed [CW-1:0]   res_y;

  logic                   accept;
  logic                   inverted;
  logic [CNT_W-1:0]       cnt_m1;
  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       mid;
  logic [SPAN_W-1:0]      in_w;
  logic [SPAN_W-1:0]      in_h;
  logic [SPAN_W-1:0]      rd_w;
  logic [SPAN_W-1:0]      rd_h;
  logic [MUL_W-1:0]       mul_a;
  logic [MUL_W-1:0]       mul_b;
  logic [2*MUL_W-1:0]     prod;
  logic                   wr_en;
  logic [IDX_W-1:0]       rd_addr;
  wrps_pkg::rect_t        wr_rect;
  logic [TOT_W-1:0]       wr_tot;
  wrps_pkg::rect_t        rd_rect;
  logic [TOT_W-1:0]       rd_tot;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign inverted = (x_right < x_left) || (y_top < y_bottom);
  assign cnt_m1   = cnt - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];
  assign mid      = lo + ((hi - lo) >> 1);

  // spans of inclusive corners, 1..65536 when not inverted
  assign in_w = {x_right[CW-1], x_right} - {x_left[CW-1], x_left} + SPAN_W'(1);
  assign in_h = {y_top[CW-1], y_top} - {y_bottom[CW-1], y_bottom} + SPAN_W'(1);
  assign rd_w = {rd_rect.xr[CW-1], rd_rect.xr} - {rd_rect.xl[CW-1], rd_rect.xl}
              + SPAN_W'(1);
  assign rd_h = {rd_rect.yt[CW-1], rd_rect.yt} - {rd_rect.yb[CW-1], rd_rect.yb}
              + SPAN_W'(1);

  assign wr_en   = (state == ST_ADD_WR);
  assign wr_rect = rect_q;
  assign wr_tot  = prev_q + prod[TOT_W-1:0];

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    rd_addr = last_idx;
    case (state)
      ST_ADD_MUL: begin
        mul_a = MUL_W'(w_q);
        mul_b = MUL_W'(h_q);
      end
      ST_PK_LO: begin
        mul_a = rsel_q;
        mul_b = rd_tot[MUL_W-1:0];
      end
      ST_PK_HI: begin
        mul_a = rsel_q;
        mul_b = MUL_W'(total_q[TOT_W-1:MUL_W]);
      end
      ST_SRCH: begin
        rd_addr = (lo < hi) ? mid : lo;
      end
      ST_MX: begin
        mul_a = rx_q;
        mul_b = MUL_W'(w_q);
      end
      ST_MY: begin
        mul_a = ry_q;
        mul_b = MUL_W'(h_q);
      end
      default: begin
        rd_addr = last_idx;
      end
    endcase
  end

  wrps_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  wrps_table #(
    .MAX_RECTS (MAX_RECTS),
    .TOT_W     (TOT_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt[IDX_W-1:0]),
    .wr_rect (wr_rect),
    .wr_tot  (wr_tot),
    .rd_addr (rd_addr),
    .rd_rect (rd_rect),
    .rd_tot  (rd_tot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // in ST_FIN the load below decides out_valid
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rect_q     <= '{xl: x_left, yb: y_bottom, xr: x_right, yt: y_top};
            rsel_q     <= rand_select;
            rx_q       <= rand_x;
            ry_q       <= rand_y;
            w_q        <= in_w;
            h_q        <= in_h;
            res_status <= wrps_pkg::STAT_OK;
            res_x      <= '0;
            res_y      <= '0;
            state      <= ST_FIN;
            unique case (cmd)
              wrps_pkg::CMD_CLEAR: begin
                cnt <= '0;
              end
              wrps_pkg::CMD_ADD: begin
                if (inverted) begin
                  res_status <= wrps_pkg::STAT_INVERTED;
                end else if (cnt == CNT_W'(MAX_RECTS)) begin
                  res_status <= wrps_pkg::STAT_FULL;
                end else begin
                  state <= ST_ADD_MUL;
                end
              end
              wrps_pkg::CMD_PICK: begin
                if (cnt == '0) begin
                  res_status <= wrps_pkg::STAT_EMPTY;
                end else begin
                  state <= ST_PK_LO;
                end
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_ADD_MUL: begin
          prev_q <= (cnt == '0) ? '0 : rd_tot;
          state  <= ST_ADD_WR;
        end
        ST_ADD_WR: begin
          cnt   <= cnt + CNT_W'(1);
          state <= ST_FIN;
        end
        ST_PK_LO: begin
          total_q <= rd_tot;
          state   <= ST_PK_HI;
        end
        ST_PK_HI: begin
          part_q <= prod[2*MUL_W-1:MUL_W];
          state  <= ST_PK_S;
        end
        ST_PK_S: begin
          // target index in 1..total
          s_q   <= prod[TOT_W-1:0] + TOT_W'(part_q) + TOT_W'(1);
          lo    <= '0;
          hi    <= last_idx;
          state <= ST_SRCH;
        end
        ST_SRCH: begin
          state <= (lo < hi) ? ST_CMP : ST_RECT;
        end
        ST_CMP: begin
          if (rd_tot >= s_q) begin
            hi <= mid;
          end else begin
            lo <= mid + IDX_W'(1);
          end
          state <= ST_SRCH;
        end
        ST_RECT: begin
          rect_q <= rd_rect;
          w_q    <= rd_w;
          h_q    <= rd_h;
          state  <= ST_MX;
        end
        ST_MX: begin
          state <= ST_MY;
        end
        ST_MY: begin
          res_x <= rect_q.xl + $signed(prod[MUL_W+CW-1:MUL_W]);
          state <= ST_FY;
        end
        ST_FY: begin
          res_y <= rect_q.yb + $signed(prod[MUL_W+CW-1:MUL_W]);
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res_status;
            point_x   <= res_x;
            point_y   <= res_y;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_RECTS))
    else $error("rectangle count beyond table depth");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH || state == ST_CMP) |-> (lo <= hi))
    else $error("search bounds crossed");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == wrps_pkg::CMD_CLEAR) |=> (cnt == '0))
    else $error("clear did not empty the table");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !(out_valid && out_stall)) |=> (out_valid && state == ST_IDLE))
    else $error("finished result not loaded");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD_WR) |=> (cnt == $past(cnt) + CNT_W'(1)))
    else $error("accepted add did not grow the table");
`endif

endmodule

### test/weighted_rect_point_sampler_unit_tb.sv
typedef struct packed {
  logic [1:0]  cmd;
  logic [15:0] xl;
  logic [15:0] yb;
  logic [15:0] xr;
  logic [15:0] yt;
  logic [31:0] rs;
  logic [31:0] rx;
  logic [31:0] ry;
} sampler_req_t;

typedef struct packed {
  logic [1:0]  status;
  logic [15:0] px;
  logic [15:0] py;
} sampler_resp_t;

class point_scoreboard;
  wrps_pkg::rect_t rects [wrps_pkg::MAX_RECTS_DEF];
  logic [63:0]     point_totals [wrps_pkg::MAX_RECTS_DEF];
  int unsigned     rect_count;
  sampler_resp_t   awaited [$];
  int              mismatches;
  int              n_picked, n_added, n_full, n_empty, n_inverted;

  function new();
    rect_count = 0;
    mismatches = 0;
    n_picked   = 0;
    n_added    = 0;
    n_full     = 0;
    n_empty    = 0;
    n_inverted = 0;
  endfunction

  // floor(r * n / 2^32)
  function logic [63:0] frac_scale(logic [31:0] r, logic [63:0] n);
    logic [95:0] prod;
    prod = 96'(r) * 96'(n);
    return prod[95:32];
  endfunction

  // lattice points along one axis, inclusive corners
  function logic [63:0] span(logic [15:0] lo, logic [15:0] hi);
    int lo_i, hi_i;
    lo_i = $signed(lo);
    hi_i = $signed(hi);
    return 64'(hi_i - lo_i + 1);
  endfunction

  function sampler_resp_t predict(sampler_req_t q);
    sampler_resp_t res;
    logic [63:0]   prev, pick_index;
    int unsigned   k;
    res = '0;
    case (q.cmd)
      wrps_pkg::CMD_CLEAR: rect_count = 0;
      wrps_pkg::CMD_ADD: begin
        if ($signed(q.xr) < $signed(q.xl) || $signed(q.yt) < $signed(q.yb)) begin
          res.status = wrps_pkg::STAT_INVERTED;
          n_inverted++;
        end else if (rect_count == wrps_pkg::MAX_RECTS_DEF) begin
          res.status = wrps_pkg::STAT_FULL;
          n_full++;
        end else begin
          prev = (rect_count != 0) ? point_totals[rect_count - 1] : 64'd0;
          rects[rect_count] = '{q.xl, q.yb, q.xr, q.yt};
          point_totals[rect_count] = prev + span(q.xl, q.xr) * span(q.yb, q.yt);
          rect_count++;
          n_added++;
        end
      end
      wrps_pkg::CMD_PICK: begin
        if (rect_count == 0) begin
          res.status = wrps_pkg::STAT_EMPTY;
          n_empty++;
        end else begin
          pick_index = frac_scale(q.rs, point_totals[rect_count - 1]) + 64'd1;
          // totals rise strictly, so a linear scan finds the same entry as a bisection
          k = 0;
          while (point_totals[k] < pick_index) k++;
          res.px = rects[k].xl + frac_scale(q.rx, span(rects[k].xl, rects[k].xr));
          res.py = rects[k].yb + frac_scale(q.ry, span(rects[k].yb, rects[k].yt));
          n_picked++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function void note_input(sampler_req_t q);
    awaited.push_back(predict(q));
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_result(logic [1:0] st, logic [15:0] px, logic [15:0] py);
    sampler_resp_t want;
    if (awaited.size() == 0) begin
      report($sformatf("unexpected result status %0d point (%0d,%0d)",
                       st, $signed(px), $signed(py)));
      return;
    end
    want = awaited.pop_front();
    if (st !== want.status)
      report($sformatf("status %0d, wanted %0d", st, want.status));
    if (px !== want.px)
      report($sformatf("point_x %0d, wanted %0d", $signed(px), $signed(want.px)));
    if (py !== want.py)
      report($sformatf("point_y %0d, wanted %0d", $signed(py), $signed(want.py)));
  endtask
endclass

module weighted_rect_point_sampler_unit_tb;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int RST_CYCLES   = 8;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd         = wrps_pkg::CMD_CLEAR;
  logic [15:0] x_left      = '0;
  logic [15:0] y_bottom    = '0;
  logic [15:0] x_right     = '0;
  logic [15:0] y_top       = '0;
  logic [31:0] rand_select = '0;
  logic [31:0] rand_x      = '0;
  logic [31:0] rand_y      = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [1:0]  status;
  logic [15:0] point_x;
  logic [15:0] point_y;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int accepted_in    = 0;
  int quiet_cycles   = 0;
  point_scoreboard sb;

  weighted_rect_point_sampler_unit dut (.*);

  always #5 clk = ~clk;

  function automatic sampler_req_t make_req(logic [1:0] c,
                                            logic [15:0] xl = '0, logic [15:0] yb = '0,
                                            logic [15:0] xr = '0, logic [15:0] yt = '0,
                                            logic [31:0] rs = '0, logic [31:0] rx = '0,
                                            logic [31:0] ry = '0);
    return '{c, xl, yb, xr, yt, rs, rx, ry};
  endfunction

  task automatic send_item(sampler_req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= q.cmd;
    x_left      <= q.xl;
    y_bottom    <= q.yb;
    x_right     <= q.xr;
    y_top       <= q.yt;
    rand_select <= q.rs;
    rand_x      <= q.rx;
    rand_y      <= q.ry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(q);
    accepted_in++;
  endtask

  task automatic send_rand_add(bit inverted_only);
    logic [15:0] a, b, c, d;
    sampler_req_t q;
    a = 16'($urandom);
    c = 16'($urandom);
    if ($urandom_range(1)) begin
      b = a + 16'($urandom_range(0, 15));
      d = c + 16'($urandom_range(0, 15));
    end else begin
      b = 16'($urandom);
      d = 16'($urandom);
    end
    if (a == b) b = a ^ 16'h0001;
    if ($signed(b) < $signed(a)) {a, b} = {b, a};
    if ($signed(d) < $signed(c)) {c, d} = {d, c};
    q = make_req(wrps_pkg::CMD_ADD, a, c, b, d);
    if (inverted_only) begin
      {q.xl, q.xr} = {q.xr, q.xl};
    end else if ($urandom_range(19) == 0) begin
      {q.yb, q.yt} = {q.yt, q.yb};
    end
    send_item(q);
  endtask

  task automatic send_rand_pick();
    logic [31:0] f [3];
    foreach (f[i]) begin
      case ($urandom_range(7))
        0:       f[i] = '0;
        1:       f[i] = '1;
        default: f[i] = $urandom;
      endcase
    end
    send_item(make_req(wrps_pkg::CMD_PICK, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), f[0], f[1], f[2]));
  endtask

  // episodes: clear, a run of adds with picks in between, sometimes past a full table
  task automatic run_phase(int items, bit first_fills);
    int first, n_adds;
    bit fill;
    first = accepted_in;
    fill  = first_fills;
    while (accepted_in - first < items) begin
      send_item(make_req(wrps_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), $urandom, $urandom, $urandom));
      if ($urandom_range(3) == 0) send_rand_pick();
      n_adds = fill ? wrps_pkg::MAX_RECTS_DEF + 4 : $urandom_range(1, 24);
      for (int i = 0; i < n_adds; i++) begin
        send_rand_add(1'b0);
        repeat ($urandom_range(0, fill ? 1 : 2)) send_rand_pick();
      end
      if (fill) begin
        send_rand_add(1'b1);
        send_rand_pick();
      end
      if ($urandom_range(15) == 0)
        send_item(make_req(CMD_SPARE, 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), $urandom, $urandom, $urandom));
      fill = ($urandom_range(7) == 0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, point_x, point_y);
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && accepted_in >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_item(make_req(wrps_pkg::CMD_PICK, '1, '1, '1, '1, '1, '1, '1));
    send_item(make_req(CMD_SPARE, '1, '1, '1, '1, '1, '1, '1));
    send_item(make_req(wrps_pkg::CMD_ADD, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
    send_item(make_req(wrps_pkg::CMD_ADD, 16'h0000, 16'h0005, 16'h0000, 16'hFFFB));
    send_item(make_req(wrps_pkg::CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_item(make_req(wrps_pkg::CMD_PICK, '0, '0, '0, '0, '0, '0, '0));
    send_item(make_req(wrps_pkg::CMD_PICK, '0, '0, '0, '0, '1, '1, '1));
    // whole coordinate plane
    send_item(make_req(wrps_pkg::CMD_ADD, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
    send_item(make_req(wrps_pkg::CMD_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(make_req(wrps_pkg::CMD_PICK, '0, '0, '0, '0, '1, '1, '1));
    send_item(make_req(wrps_pkg::CMD_PICK, '0, '0, '0, '0, '0, '1, '0));
    send_item(make_req(wrps_pkg::CMD_PICK, '0, '0, '0, '0, 32'h8000_0000, 32'h5555_5555,
                       32'hAAAA_AAAA));
    send_item(make_req(wrps_pkg::CMD_ADD, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555));
    send_item(make_req(wrps_pkg::CMD_PICK, '0, '0, '0, '0, 32'hAAAA_AAAA, 32'h5555_5555,
                       '1));
    send_item(make_req(wrps_pkg::CMD_ADD, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
    send_item(make_req(wrps_pkg::CMD_CLEAR));
    send_item(make_req(wrps_pkg::CMD_PICK, '0, '0, '0, '0, '1, '1, '1));
    send_item(make_req(wrps_pkg::CMD_ADD, 16'h0000, 16'h0003, 16'h0000, 16'h0003));
    send_item(make_req(wrps_pkg::CMD_PICK, '0, '0, '0, '0, 32'h1234_5678, 32'h9ABC_DEF0,
                       32'h0F0F_0F0F));

    send_idle_pct  = 11;
    recv_stall_pct = 79;
    run_phase(133, 1'b1);
    send_idle_pct  = 79;
    recv_stall_pct = 11;
    run_phase(133, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(134, 1'b0);
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d transfers in, %0d rectangles stored, %0d points picked",
             accepted_in, sb.n_added, sb.n_picked);
    $display("summary: %0d empty-table picks, %0d full-table adds, %0d inverted adds",
             sb.n_empty, sb.n_full, sb.n_inverted);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
